// ===== rtl/sfga_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sfga_pkg;

  // Fixed field widths
  localparam int FRAME_BITS_W = 6;
  localparam int REG_W        = 24;
  localparam int CFG_INDEX_W  = 3;
  localparam int TIMER_WIDTH_DEFAULT = 24;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BITS     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_TIMEOUT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALIGN_WINDOW   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF_DELAY  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP_DELAY      = 3'd4;

  // Register reset values
  localparam logic [FRAME_BITS_W-1:0] RST_FRAME_BITS     = 6'd24;
  localparam logic [REG_W-1:0]        RST_ACTIVE_TIMEOUT = 24'd500000;
  localparam logic [REG_W-1:0]        RST_ALIGN_WINDOW   = 24'd30000;
  localparam logic [REG_W-1:0]        RST_BACKOFF_DELAY  = 24'd20000;
  localparam logic [REG_W-1:0]        RST_GAP_DELAY      = 24'd110000;

  typedef struct packed {
    logic start_search;
    logic clock_level;
  } in_t;

  typedef struct packed {
    logic power_on;
    logic searching;
    logic frame_start_pulse;
    logic timeout_pulse;
  } out_t;

  typedef struct packed {
    logic [FRAME_BITS_W-1:0] frame_bits;
    logic [REG_W-1:0]        active_timeout;
    logic [REG_W-1:0]        align_window;
    logic [REG_W-1:0]        backoff_delay;
    logic [REG_W-1:0]        gap_delay;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/serial_frame_gap_aligner_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Serial frame gap aligner. Each input transfer is one sample tick of the
// serial clock pin (clock_level) plus a start request (start_search). A start
// while idle arms a search bounded by active_timeout; within each align_window
// the block counts falling clock edges, backs off for backoff_delay and retries
// when a window closes short of frame_bits edges, and on a full frame waits for
// the clock to go high, sets power_on, waits gap_delay and pulses
// frame_start_pulse. If the overall timeout fires first (also while waiting
// for the clock to go high) power_on clears and timeout_pulse fires. Every
// input transfer yields exactly one output transfer showing the state after
// that tick. Throughput is one tick per clock: the state update is a single
// registered pass, and a two-slot output register (head plus skid) keeps
// in_ready high while one result waits, so in_ready drops only when two
// results are pending. Configuration writes (cfg_ready is always high) must be
// made while idle; indexes beyond gap_delay are ignored. Timers are TIMER_WIDTH
// bits, saturate, and compare register values above their maximum as that
// maximum.

module serial_frame_gap_aligner_top #(
  parameter int TIMER_WIDTH = sfga_pkg::TIMER_WIDTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // tick input channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  sfga_pkg::in_t                         in_data,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output sfga_pkg::out_t                        out_data,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sfga_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sfga_pkg::REG_W-1:0]       cfg_data
);

  sfga_pkg::cfg_t cfg;
  sfga_pkg::out_t result;
  logic           step;

  assign cfg_ready = 1'b1;
  // one tick advances the state exactly when its transfer completes
  assign step = in_valid && in_ready;

  sfga_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sfga_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_data),
    .cfg    (cfg),
    .result (result)
  );

  // result register with skid slot
  sfga_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_data  (result),
    .can_push   (in_ready),
    .head_valid (out_valid),
    .head_ready (out_ready),
    .head_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/sfga_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfga_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [sfga_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire logic [sfga_pkg::REG_W-1:0]       wr_data,
  output sfga_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_bits     <= sfga_pkg::RST_FRAME_BITS;
      cfg.active_timeout <= sfga_pkg::RST_ACTIVE_TIMEOUT;
      cfg.align_window   <= sfga_pkg::RST_ALIGN_WINDOW;
      cfg.backoff_delay  <= sfga_pkg::RST_BACKOFF_DELAY;
      cfg.gap_delay      <= sfga_pkg::RST_GAP_DELAY;
    end else if (wr_en) begin
      case (wr_index)
        sfga_pkg::REG_FRAME_BITS:
          cfg.frame_bits <= wr_data[sfga_pkg::FRAME_BITS_W-1:0];
        sfga_pkg::REG_ACTIVE_TIMEOUT: cfg.active_timeout <= wr_data;
        sfga_pkg::REG_ALIGN_WINDOW:   cfg.align_window   <= wr_data;
        sfga_pkg::REG_BACKOFF_DELAY:  cfg.backoff_delay  <= wr_data;
        sfga_pkg::REG_GAP_DELAY:      cfg.gap_delay      <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfga_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfga_core #(
  parameter int TIMER_WIDTH = sfga_pkg::TIMER_WIDTH_DEFAULT
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    step,
  input  sfga_pkg::in_t  item,
  input  sfga_pkg::cfg_t cfg,
  output sfga_pkg::out_t result
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_COUNT    = 3'd1;
  localparam logic [2:0] PH_BACKOFF  = 3'd2;
  localparam logic [2:0] PH_WAITHIGH = 3'd3;
  localparam logic [2:0] PH_GAP      = 3'd4;

  localparam int CW = (TIMER_WIDTH > sfga_pkg::REG_W) ? TIMER_WIDTH : sfga_pkg::REG_W;
  localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};
  localparam logic [CW-1:0] TMAX_EXT = CW'(TMAX);

  typedef logic [TIMER_WIDTH-1:0] tmr_t;

  // Register value limited to what a counter can reach
  function automatic tmr_t clamp(input logic [sfga_pkg::REG_W-1:0] v);
    logic [CW-1:0] e;
    begin
      e = CW'(v);
      clamp = (e > TMAX_EXT) ? TMAX : e[TIMER_WIDTH-1:0];
    end
  endfunction

  // Saturating increment
  function automatic tmr_t inc(input tmr_t c);
    begin
      inc = (c == TMAX) ? TMAX : c + 1'b1;
    end
  endfunction

  logic [2:0]                        phase, phase_next;
  logic [sfga_pkg::FRAME_BITS_W-1:0] edge_count, edge_count_next;
  logic                              last_clock;
  tmr_t                              overall_ticks, overall_ticks_next;
  tmr_t                              window_ticks, window_ticks_next;
  tmr_t                              delay_ticks, delay_ticks_next;
  logic                              powered, powered_next;

  logic                              fall;
  logic                              fs, to;
  tmr_t                              ov_inc, win_inc, dly_inc;
  logic [sfga_pkg::FRAME_BITS_W-1:0] edge_inc;

  assign fall     = last_clock && !item.clock_level;
  assign ov_inc   = inc(overall_ticks);
  assign win_inc  = inc(window_ticks);
  assign dly_inc  = inc(delay_ticks);
  assign edge_inc = edge_count + 1'b1;

  always_comb begin
    phase_next         = phase;
    edge_count_next    = edge_count;
    overall_ticks_next = overall_ticks;
    window_ticks_next  = window_ticks;
    delay_ticks_next   = delay_ticks;
    powered_next       = powered;
    fs                 = 1'b0;
    to                 = 1'b0;
    case (phase)
      PH_COUNT, PH_BACKOFF, PH_WAITHIGH: begin
        overall_ticks_next = ov_inc;
        if (ov_inc >= clamp(cfg.active_timeout)) begin
          powered_next = 1'b0;
          phase_next   = PH_IDLE;
          to           = 1'b1;
        end else if (phase == PH_COUNT) begin
          window_ticks_next = win_inc;
          if (win_inc >= clamp(cfg.align_window)) begin
            phase_next       = PH_BACKOFF;
            delay_ticks_next = '0;
          end else if (fall) begin
            edge_count_next = edge_inc;
            // a wrap to zero also ends the frame
            if (edge_inc == '0 || edge_inc >= cfg.frame_bits) begin
              phase_next = PH_WAITHIGH;
            end
          end
        end else if (phase == PH_BACKOFF) begin
          delay_ticks_next = dly_inc;
          if (dly_inc >= clamp(cfg.backoff_delay)) begin
            phase_next        = PH_COUNT;
            window_ticks_next = '0;
            edge_count_next   = '0;
          end
        end else if (item.clock_level) begin
          powered_next     = 1'b1;
          phase_next       = PH_GAP;
          delay_ticks_next = '0;
        end
      end
      PH_GAP: begin
        delay_ticks_next = dly_inc;
        if (dly_inc >= clamp(cfg.gap_delay)) begin
          phase_next = PH_IDLE;
          fs         = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (item.start_search) begin
          phase_next         = PH_COUNT;
          overall_ticks_next = '0;
          window_ticks_next  = '0;
          delay_ticks_next   = '0;
          edge_count_next    = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      edge_count    <= '0;
      last_clock    <= 1'b0;
      overall_ticks <= '0;
      window_ticks  <= '0;
      delay_ticks   <= '0;
      powered       <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      edge_count    <= edge_count_next;
      last_clock    <= item.clock_level;
      overall_ticks <= overall_ticks_next;
      window_ticks  <= window_ticks_next;
      delay_ticks   <= delay_ticks_next;
      powered       <= powered_next;
    end
  end

  assign result.power_on          = powered_next;
  assign result.searching         = (phase_next != PH_IDLE);
  assign result.frame_start_pulse = fs;
  assign result.timeout_pulse     = to;

endmodule

`default_nettype wire

// ===== rtl/sfga_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfga_outq (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  sfga_pkg::out_t  push_data,
  output logic          can_push,
  output logic          head_valid,
  input  wire logic     head_ready,
  output sfga_pkg::out_t  head_data
);

  logic           skid_valid;
  sfga_pkg::out_t skid;
  logic           pop;

  assign can_push = !skid_valid;
  assign pop      = head_valid && head_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (head_valid && !pop) begin
      // head stalled: a new transfer parks in the skid slot
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      head_valid <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      head_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (head_valid && !pop) begin
      if (push) begin
        skid <= push_data;
      end
    end else if (skid_valid) begin
      head_data <= skid;
    end else if (push) begin
      head_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sfga_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sfga_checker (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input sfga_pkg::out_t  out_data
);

  // frame start and timeout end a search in different ways
  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.frame_start_pulse && out_data.timeout_pulse))
    else $error("frame start and timeout in one result");

  a_timeout_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.timeout_pulse) |-> (!out_data.power_on && !out_data.searching))
    else $error("timeout result not idle and powered off");

  a_frame_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.frame_start_pulse) |-> (out_data.power_on && !out_data.searching))
    else $error("frame start result not idle and powered on");

  // with no result waiting the block must take a tick
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind serial_frame_gap_aligner_top sfga_checker u_sfga_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
